>>> hdl/lz77w_pkg.sv
// Shared types and constants of the sliding-window LZ77 encoder.
// Used by lz77w_match and by the top level lz77_window_encoder.
`default_nettype none

package lz77w_pkg;

    // Window depth in bytes and the longest match a token may carry.
    localparam int WINDOW  = 5;
    localparam int MAX_LEN = 255;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = $clog2(WINDOW + 1);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int OFF_W   = 3;
    localparam int TLEN_W  = 8;

    localparam logic [LEN_W-1:0] MAX_RUN = LEN_W'(MAX_LEN);

    typedef logic [BYTE_W-1:0] byte_t;

    // Encoder state; entry 0 of the history is the most recent byte.
    typedef struct packed {
        logic [WINDOW-1:0][BYTE_W-1:0] hist;
        logic [COUNT_W-1:0]            count;
        logic [WINDOW-1:0]             live;
        logic [LEN_W-1:0]              run;
    } lz77w_state_t;

    typedef struct packed {
        logic              emit;
        logic [OFF_W-1:0]  offset;
        logic [TLEN_W-1:0] length;
        byte_t             literal;
        logic              eos;
    } lz77w_token_t;

    // Smallest offset whose bit is set in the mask, or zero for an empty mask.
    function automatic logic [OFF_W-1:0] lowest_offset(input logic [WINDOW-1:0] mask);
        logic [OFF_W-1:0] result;
        result = '0;
        for (int d = WINDOW - 1; d >= 0; d--) begin
            if (mask[d]) begin
                result = OFF_W'(d + 1);
            end
        end
        return result;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lz77w_match.sv
// Match step of the LZ77 encoder: compares one byte against every window
// offset in parallel and yields the next state and the token, if any.
// Depends on lz77w_pkg.
`default_nettype none

module lz77w_match (
    input  lz77w_pkg::lz77w_state_t cur,
    input  lz77w_pkg::byte_t        data_byte,
    input  logic                    last_byte,
    output lz77w_pkg::lz77w_state_t nxt,
    output lz77w_pkg::lz77w_token_t tok
);
    import lz77w_pkg::*;

    logic [WINDOW-1:0] cand;
    logic [WINDOW-1:0] hits;
    logic [LEN_W-1:0]  run_inc;
    logic              at_max;

    // A fresh match may start at any offset that already holds a byte.
    always_comb begin
        for (int d = 0; d < WINDOW; d++) begin
            if (cur.run == '0) begin
                cand[d] = (COUNT_W'(d) < cur.count);
            end else begin
                cand[d] = cur.live[d];
            end
            hits[d] = cand[d] && (cur.hist[d] == data_byte);
        end
    end

    assign at_max  = (cur.run == MAX_RUN);
    assign run_inc = cur.run + LEN_W'(1);

    always_comb begin
        nxt         = cur;
        tok.emit    = 1'b0;
        tok.offset  = '0;
        tok.length  = '0;
        tok.literal = data_byte;
        tok.eos     = last_byte;

        if (at_max) begin
            tok.emit   = 1'b1;
            tok.offset = lowest_offset(cur.live);
            tok.length = TLEN_W'(cur.run);
            nxt.run    = '0;
            nxt.live   = '0;
        end else if (hits != '0) begin
            nxt.run  = run_inc;
            nxt.live = hits;
            // The stream ends inside a match: the final byte is part of it.
            if (last_byte) begin
                tok.emit    = 1'b1;
                tok.offset  = lowest_offset(hits);
                tok.length  = TLEN_W'(run_inc);
                tok.literal = '0;
                tok.eos     = 1'b1;
            end
        end else begin
            tok.emit   = 1'b1;
            tok.offset = (cur.run != '0) ? lowest_offset(cur.live) : '0;
            tok.length = TLEN_W'(cur.run);
            nxt.run    = '0;
            nxt.live   = '0;
        end

        for (int d = WINDOW - 1; d > 0; d--) begin
            nxt.hist[d] = cur.hist[d-1];
        end
        nxt.hist[0] = data_byte;
        if (cur.count < COUNT_W'(WINDOW)) begin
            nxt.count = cur.count + COUNT_W'(1);
        end

        if (last_byte) begin
            nxt = '0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lz77_window_encoder.sv
// Top level of the streaming LZ77 encoder over a five-byte sliding window.
// Depends on lz77w_pkg and lz77w_match.
`default_nettype none

// The encoder takes one byte per clock cycle unless its output is stalled
// and emits a token (offset, length, next literal, end flag) in the cycle
// after a byte that does not extend the current match or ends the stream.
// Every window offset is compared against the incoming byte in the same
// cycle, so the throughput is one byte per cycle. A single output register
// holds the pending token; a new byte is taken whenever it is empty or its
// token is transferred in the same cycle. State resets after the final byte.
module lz77_window_encoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lz77w_pkg::BYTE_W-1:0]         s_data_byte,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lz77w_pkg::OFF_W-1:0]          m_match_offset,
    output logic [lz77w_pkg::TLEN_W-1:0]         m_match_length,
    output logic [lz77w_pkg::BYTE_W-1:0]         m_next_literal,
    output logic                                 m_end_of_stream
);
    import lz77w_pkg::*;

    lz77w_state_t state_reg;
    lz77w_state_t state_next;
    lz77w_token_t tok;
    lz77w_token_t tok_reg;
    logic         m_valid_reg;
    logic         s_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    lz77w_match u_match (
        .cur       (state_reg),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .nxt       (state_next),
        .tok       (tok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= tok.emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && tok.emit) begin
            tok_reg <= tok;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_match_offset  = tok_reg.offset;
    assign m_match_length  = tok_reg.length;
    assign m_next_literal  = tok_reg.literal;
    assign m_end_of_stream = tok_reg.eos;

endmodule

`default_nettype wire

>>> hdl/lz77w_checker.sv
// Port-level checks for lz77_window_encoder, attached by the bind below.
// Depends on lz77w_pkg.
`default_nettype none

module lz77w_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [lz77w_pkg::BYTE_W-1:0]  s_data_byte,
    input logic                          s_last_byte,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [lz77w_pkg::OFF_W-1:0]   m_match_offset,
    input logic [lz77w_pkg::TLEN_W-1:0]  m_match_length,
    input logic [lz77w_pkg::BYTE_W-1:0]  m_next_literal,
    input logic                          m_end_of_stream
);
    import lz77w_pkg::*;

    // A stalled token keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_offset)
            && $stable(m_match_length) && $stable(m_next_literal)
            && $stable(m_end_of_stream))
        else $error("token changed while stalled");

    // The final byte of a stream always closes a token.
    a_last_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_byte |=> m_valid && m_end_of_stream)
        else $error("final byte produced no end-of-stream token");

    // An offset is reported exactly when some bytes were copied.
    a_off_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_match_offset == '0) == (m_match_length == '0)))
        else $error("offset and length disagree");

    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_match_offset) <= 32'(WINDOW)))
        else $error("offset beyond the window");

    // Input is refused only while a token waits to be transferred.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without a stalled token");

endmodule

bind lz77_window_encoder lz77w_checker u_lz77w_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_data_byte     (s_data_byte),
    .s_last_byte     (s_last_byte),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_match_offset  (m_match_offset),
    .m_match_length  (m_match_length),
    .m_next_literal  (m_next_literal),
    .m_end_of_stream (m_end_of_stream)
);

`default_nettype wire
